/* src/bq_pkg.sv */
// Package: shared types, widths and the microcode table of the biquad section.
`timescale 1ns / 1ps
`default_nettype none
package bq_pkg;

   localparam int SampleWidth = 16;
   localparam int CoefWidth   = 16;
   localparam int DelayWidth  = 24;
   localparam int ProdWidth   = CoefWidth + DelayWidth;
   localparam int FracShift   = 14;
   localparam int TermWidth   = ProdWidth - FracShift;
   localparam int AccWidth    = TermWidth + 2;
   localparam int CsrIdxWidth = 3;
   localparam int CsrWidth    = DelayWidth;
   localparam int StepWidth   = 3;

   localparam logic [CsrIdxWidth-1:0] CSR_B0  = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_B1  = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_B2  = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_A1  = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_A2  = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CSR_THR = 3'd5;

   localparam logic signed [CoefWidth-1:0]  B0_RESET  = 16'sd16384;
   localparam logic signed [DelayWidth-1:0] THR_RESET = 24'sd12288;

   typedef enum logic [2:0] {
      MUL_A1_NEWER,
      MUL_A2_OLDER,
      MUL_B1_NEWER,
      MUL_B2_OLDER,
      MUL_B0_MID
   } mul_sel_type;

   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_X_SUB,
      ACC_SUB,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   typedef struct packed {
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        mid_load;
      logic        wait_in;
      logic        commit;
   } ucode_type;

   typedef struct packed {
      logic signed [CoefWidth-1:0]  b0;
      logic signed [CoefWidth-1:0]  b1;
      logic signed [CoefWidth-1:0]  b2;
      logic signed [CoefWidth-1:0]  a1;
      logic signed [CoefWidth-1:0]  a2;
      logic signed [DelayWidth-1:0] thr;
   } coef_type;

   // Program ROM. Step 0 waits for a sample, step 6 waits for the output slot.
   function automatic ucode_type ucode(input logic [StepWidth-1:0] step);
      ucode_type w;
      w = '{mul_sel: MUL_A1_NEWER, acc_op: ACC_HOLD, mid_load: 1'b0,
            wait_in: 1'b0, commit: 1'b0};
      case (step)
         3'd0: begin
            w.mul_sel = MUL_A1_NEWER;
            w.wait_in = 1'b1;
         end
         3'd1: begin
            w.mul_sel = MUL_A2_OLDER;
            w.acc_op  = ACC_X_SUB;
         end
         3'd2: begin
            w.mul_sel = MUL_B1_NEWER;
            w.acc_op  = ACC_SUB;
         end
         3'd3: begin
            w.mul_sel  = MUL_B2_OLDER;
            w.acc_op   = ACC_LOAD;
            w.mid_load = 1'b1;
         end
         3'd4: begin
            w.mul_sel = MUL_B0_MID;
            w.acc_op  = ACC_ADD;
         end
         3'd5: begin
            w.acc_op = ACC_ADD;
         end
         3'd6: begin
            w.commit = 1'b1;
         end
         default: begin
            w.commit = 1'b1;
         end
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

/* src/bq_req_if.sv */
// Interface: input sample channel.
`timescale 1ns / 1ps
`default_nettype none
interface bq_req_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [bq_pkg::SampleWidth-1:0]   sample_in;
   logic                                    last_in_block;

   modport source (output valid, output sample_in, output last_in_block, input ready);
   modport sink   (input valid, input sample_in, input last_in_block, output ready);
endinterface
`default_nettype wire

/* src/bq_rsp_if.sv */
// Interface: filtered sample channel.
`timescale 1ns / 1ps
`default_nettype none
interface bq_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [bq_pkg::SampleWidth-1:0]   sample_out;
   logic                                    cleared;
   logic                                    last_out;

   modport source (output valid, output sample_out, output cleared, output last_out,
                   input ready);
   modport sink   (input valid, input sample_out, input cleared, input last_out,
                   output ready);
endinterface
`default_nettype wire

/* src/bq_datapath.sv */
// Datapath: shared multiplier, accumulator, middle register and delay line.
`timescale 1ns / 1ps
`default_nettype none
module bq_datapath (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire bq_pkg::ucode_type                     ctl,
   input  wire logic                                  commit_en,
   input  wire bq_pkg::coef_type                      coef,
   input  wire logic signed [bq_pkg::SampleWidth-1:0] x,
   output logic signed [bq_pkg::SampleWidth-1:0]      y_sat,
   output logic                                       clr
);

   localparam int AW = bq_pkg::AccWidth;
   localparam int DW = bq_pkg::DelayWidth;
   localparam int SW = bq_pkg::SampleWidth;

   logic signed [DW-1:0] newer_ff, newer_in, older_ff, older_in, mid_ff, mid_in;
   logic signed [bq_pkg::ProdWidth-1:0] prod_ff, prod_in;
   logic signed [AW-1:0] acc_ff, acc_in, term, thr_ext;
   logic signed [bq_pkg::CoefWidth-1:0] mul_c;
   logic signed [DW-1:0] mul_v;

   always_comb begin
      case (ctl.mul_sel)
         bq_pkg::MUL_A1_NEWER: begin mul_c = coef.a1; mul_v = newer_ff; end
         bq_pkg::MUL_A2_OLDER: begin mul_c = coef.a2; mul_v = older_ff; end
         bq_pkg::MUL_B1_NEWER: begin mul_c = coef.b1; mul_v = newer_ff; end
         bq_pkg::MUL_B2_OLDER: begin mul_c = coef.b2; mul_v = older_ff; end
         bq_pkg::MUL_B0_MID:   begin mul_c = coef.b0; mul_v = mid_ff;   end
         default:              begin mul_c = coef.a1; mul_v = newer_ff; end
      endcase
      prod_in = mul_c * mul_v;
   end

   // floor(prod / 2^14), sign kept
   assign term = AW'($signed(prod_ff[bq_pkg::ProdWidth-1:bq_pkg::FracShift]));

   always_comb begin
      case (ctl.acc_op)
         bq_pkg::ACC_X_SUB: acc_in = AW'(x) - term;
         bq_pkg::ACC_SUB:   acc_in = acc_ff - term;
         bq_pkg::ACC_LOAD:  acc_in = term;
         bq_pkg::ACC_ADD:   acc_in = acc_ff + term;
         default:           acc_in = acc_ff;
      endcase
   end

   // saturate middle value to the delay format
   always_comb begin
      if (acc_ff[AW-1:DW-1] == '0 || acc_ff[AW-1:DW-1] == '1) begin
         mid_in = acc_ff[DW-1:0];
      end else if (acc_ff[AW-1]) begin
         mid_in = {1'b1, {(DW-1){1'b0}}};
      end else begin
         mid_in = {1'b0, {(DW-1){1'b1}}};
      end
   end

   // output saturation and clear test on the full-precision result
   always_comb begin
      if (acc_ff[AW-1:SW-1] == '0 || acc_ff[AW-1:SW-1] == '1) begin
         y_sat = acc_ff[SW-1:0];
      end else if (acc_ff[AW-1]) begin
         y_sat = {1'b1, {(SW-1){1'b0}}};
      end else begin
         y_sat = {1'b0, {(SW-1){1'b1}}};
      end
      thr_ext = AW'(coef.thr);
      clr     = acc_ff > thr_ext;
   end

   always_comb begin
      newer_in = newer_ff;
      older_in = older_ff;
      if (commit_en) begin
         newer_in = mid_ff;
         older_in = clr ? '0 : newer_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (ctl.mid_load) begin
         mid_ff <= mid_in;
      end
      if (reset) begin
         newer_ff <= '0;
         older_ff <= '0;
      end else begin
         newer_ff <= newer_in;
         older_ff <= older_in;
      end
   end

endmodule
`default_nettype wire

/* src/biquad_df2_with_overload_clear.sv */
// Top level: microcoded direct form II biquad with overload clear.
`timescale 1ns / 1ps
`default_nettype none
// Direct form II biquad, one Q2.13 sample per beat on req_ch, one result beat
// on rsp_ch. A 7-step program ROM drives a single shared 16x24 multiplier:
// the two feedback products, the saturated middle value, then the three
// feedforward products. A new sample is taken only once the previous one has
// run through the whole program and been committed to the result register.
// The sequencer waits in step 0 for a sample and in the last step until the
// result register is free; the result register is reloaded in the same cycle
// its previous beat is taken. If the unsaturated result exceeds
// clear_threshold (strictly), both delay entries are zeroed before the middle
// value shifts in, and cleared is flagged on that beat.
// Coefficient and threshold writes on the csr_ port take effect at once and
// must only be issued while no sample is in flight; unused indexes are ignored.
module biquad_df2_with_overload_clear (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   bq_req_if.sink                                    req_ch,
   bq_rsp_if.source                                  rsp_ch,
   input  wire logic                                 csr_we,
   input  wire logic [bq_pkg::CsrIdxWidth-1:0]       csr_index,
   input  wire logic [bq_pkg::CsrWidth-1:0]          csr_wdata
);

   logic [bq_pkg::StepWidth-1:0] step_ff, step_in;
   bq_pkg::ucode_type            ctl;
   bq_pkg::coef_type             coef_ff;
   logic signed [bq_pkg::SampleWidth-1:0] x_ff, y_sat, sample_out_ff;
   logic last_ff, last_out_ff, cleared_ff, rsp_valid_ff, rsp_valid_in;
   logic clr, in_fire, out_free, commit_en;

   assign ctl = bq_pkg::ucode(step_ff);

   // handshake
   assign req_ch.ready = ctl.wait_in;
   assign in_fire      = req_ch.valid & ctl.wait_in;
   assign out_free     = ~rsp_valid_ff | rsp_ch.ready;
   assign commit_en    = ctl.commit & out_free;

   // sequencer: hold on a wait step, restart after commit
   always_comb begin
      step_in = step_ff + 1'b1;
      if (ctl.wait_in && !req_ch.valid) begin
         step_in = step_ff;
      end else if (ctl.commit) begin
         step_in = out_free ? '0 : step_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   bq_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .commit_en (commit_en),
      .coef      (coef_ff),
      .x         (x_ff),
      .y_sat     (y_sat),
      .clr       (clr)
   );

   always_ff @(posedge clock) begin
      if (in_fire) begin
         x_ff    <= req_ch.sample_in;
         last_ff <= req_ch.last_in_block;
      end
      if (commit_en) begin
         sample_out_ff <= y_sat;
         cleared_ff    <= clr;
         last_out_ff   <= last_ff;
      end
      if (reset) begin
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.b0  <= bq_pkg::B0_RESET;
         coef_ff.b1  <= '0;
         coef_ff.b2  <= '0;
         coef_ff.a1  <= '0;
         coef_ff.a2  <= '0;
         coef_ff.thr <= bq_pkg::THR_RESET;
      end else if (csr_we) begin
         case (csr_index)
            bq_pkg::CSR_B0:  coef_ff.b0  <= csr_wdata[bq_pkg::CoefWidth-1:0];
            bq_pkg::CSR_B1:  coef_ff.b1  <= csr_wdata[bq_pkg::CoefWidth-1:0];
            bq_pkg::CSR_B2:  coef_ff.b2  <= csr_wdata[bq_pkg::CoefWidth-1:0];
            bq_pkg::CSR_A1:  coef_ff.a1  <= csr_wdata[bq_pkg::CoefWidth-1:0];
            bq_pkg::CSR_A2:  coef_ff.a2  <= csr_wdata[bq_pkg::CoefWidth-1:0];
            bq_pkg::CSR_THR: coef_ff.thr <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.sample_out = sample_out_ff;
   assign rsp_ch.cleared    = cleared_ff;
   assign rsp_ch.last_out   = last_out_ff;

endmodule
`default_nettype wire

/* bench/biquad_df2_with_overload_clear_tb.sv */
// Testbench: directed and random samples through the biquad, every result beat checked.
`timescale 1ns / 1ps
module biquad_df2_with_overload_clear_tb;

   localparam int SampleWidth = bq_pkg::SampleWidth;
   localparam int CoefWidth   = bq_pkg::CoefWidth;
   localparam int DelayWidth  = bq_pkg::DelayWidth;
   localparam int CsrWidth    = bq_pkg::CsrWidth;
   localparam int CsrIdxWidth = bq_pkg::CsrIdxWidth;
   localparam int FracShift   = bq_pkg::FracShift;

   // Run shape
   localparam int DrainCycles   = 12;     // > 7-step program, covers a beat still in flight
   localparam int EndWaitCycles = 5000;   // cap on the final wait for outstanding beats
   localparam int RandomItems   = 1725;
   localparam int PhaseLen      = 125;    // random beats between coefficient reloads
   localparam int MaxReports    = 10;
   localparam int SteadyFirst   = 700;    // random beats in [SteadyFirst, SteadyLast) get no random idle gaps
   localparam int SteadyLast    = 1000;

   // Indexes the block decodes as nothing
   localparam logic [CsrIdxWidth-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CsrIdxWidth-1:0] CSR_SPARE_HI = 3'd7;

   // Saturation bounds of the middle value (Q10.13) and of the output (Q2.13)
   localparam longint MidMax = (longint'(1) <<< (DelayWidth - 1)) - 1;
   localparam longint OutMax = (longint'(1) <<< (SampleWidth - 1)) - 1;

   typedef struct packed {
      logic signed [SampleWidth-1:0] smp;
      logic                          cleared;
      logic                          last;
   } filt_beat_type;

   typedef enum bit {ROW_SAMPLE, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type                  kind;
      logic [CsrIdxWidth-1:0]        idx;
      logic [CsrWidth-1:0]           wdata;
      logic signed [SampleWidth-1:0] smp;
      logic                          last;
      bit                            typed;   // y/clr below hold the expected beat
      logic signed [SampleWidth-1:0] y;
      logic                          clr;
   } plan_row_type;

   logic clock;
   logic reset;
   logic                   csr_we;
   logic [CsrIdxWidth-1:0] csr_index;
   logic [CsrWidth-1:0]    csr_wdata;

   bq_req_if req_ch ();
   bq_rsp_if rsp_ch ();

   biquad_df2_with_overload_clear dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the coefficient bank and the two-entry delay line
   logic signed [CoefWidth-1:0]  gain_b0, gain_b1, gain_b2, gain_a1, gain_a2;
   logic signed [DelayWidth-1:0] clip_thr;
   logic signed [DelayWidth-1:0] hist_newer, hist_older;

   filt_beat_type expected_beats [$];
   int  mismatches = 0;
   bit  steady = 1'b0;   // both sides run flat out while set

   // Directed part. Up to row 12 only b0 is nonzero, so every output is b0*x and can be
   // typed in; the feedback run at the end drives the middle value into saturation.
   localparam int PlanLen = 24;
   plan_row_type plan [PlanLen] = '{
      // reset bank: unity gain, threshold 1.5
      '{ROW_SAMPLE, bq_pkg::CSR_B0, '0, 16'sh0000, 1'b0, 1'b1, 16'sh0000, 1'b0},
      '{ROW_SAMPLE, bq_pkg::CSR_B0, '0, 16'sh7FFF, 1'b1, 1'b1, 16'sh7FFF, 1'b1},
      '{ROW_SAMPLE, bq_pkg::CSR_B0, '0, 16'sh8000, 1'b0, 1'b1, 16'sh8000, 1'b0},
      // exactly at threshold: no clear; one LSB above: clear
      '{ROW_SAMPLE, bq_pkg::CSR_B0, '0, 16'sh3000, 1'b0, 1'b1, 16'sh3000, 1'b0},
      '{ROW_SAMPLE, bq_pkg::CSR_B0, '0, 16'sh3001, 1'b1, 1'b1, 16'sh3001, 1'b1},
      // b0 = -2.0, junk above bit 15; spare index must not land anywhere
      '{ROW_WRITE,  bq_pkg::CSR_B0, 24'h5A8000, 16'sh0, 1'b0, 1'b0, 16'sh0, 1'b0},
      '{ROW_WRITE,  CSR_SPARE_LO,   24'h004000, 16'sh0, 1'b0, 1'b0, 16'sh0, 1'b0},
      // output overflow both ways: (-2)*(-4) = +8 -> clip high, (-2)*(~4) -> clip low
      '{ROW_SAMPLE, bq_pkg::CSR_B0, '0, 16'sh8000, 1'b0, 1'b1, 16'sh7FFF, 1'b1},
      '{ROW_SAMPLE, bq_pkg::CSR_B0, '0, 16'sh7FFF, 1'b1, 1'b1, 16'sh8000, 1'b0},
      // most negative threshold: even a zero result clears
      '{ROW_WRITE,  bq_pkg::CSR_THR, 24'h800000, 16'sh0, 1'b0, 1'b0, 16'sh0, 1'b0},
      '{ROW_WRITE,  CSR_SPARE_HI,    24'h7FFFFF, 16'sh0, 1'b0, 1'b0, 16'sh0, 1'b0},
      '{ROW_SAMPLE, bq_pkg::CSR_B0, '0, 16'sh0000, 1'b0, 1'b1, 16'sh0000, 1'b1},
      // a1 = -2.0 doubles the feedback each beat until mid pins at full scale
      '{ROW_WRITE,  bq_pkg::CSR_THR, 24'h7FFFFF, 16'sh0, 1'b0, 1'b0, 16'sh0, 1'b0},
      '{ROW_WRITE,  bq_pkg::CSR_A1,  24'hFF8000, 16'sh0, 1'b0, 1'b0, 16'sh0, 1'b0},
      '{ROW_WRITE,  bq_pkg::CSR_B0,  24'h007FFF, 16'sh0, 1'b0, 1'b0, 16'sh0, 1'b0},
      '{ROW_SAMPLE, bq_pkg::CSR_B0, '0, 16'sh7FFF, 1'b0, 1'b0, 16'sh0, 1'b0},
      '{ROW_SAMPLE, bq_pkg::CSR_B0, '0, 16'sh7FFF, 1'b1, 1'b0, 16'sh0, 1'b0},
      '{ROW_SAMPLE, bq_pkg::CSR_B0, '0, 16'sh7FFF, 1'b0, 1'b0, 16'sh0, 1'b0},
      '{ROW_SAMPLE, bq_pkg::CSR_B0, '0, 16'sh7FFF, 1'b1, 1'b0, 16'sh0, 1'b0},
      '{ROW_SAMPLE, bq_pkg::CSR_B0, '0, 16'sh7FFF, 1'b0, 1'b0, 16'sh0, 1'b0},
      '{ROW_SAMPLE, bq_pkg::CSR_B0, '0, 16'sh7FFF, 1'b1, 1'b0, 16'sh0, 1'b0},
      '{ROW_SAMPLE, bq_pkg::CSR_B0, '0, 16'sh7FFF, 1'b0, 1'b0, 16'sh0, 1'b0},
      '{ROW_SAMPLE, bq_pkg::CSR_B0, '0, 16'sh7FFF, 1'b1, 1'b0, 16'sh0, 1'b0},
      '{ROW_SAMPLE, bq_pkg::CSR_B0, '0, 16'sh7FFF, 1'b0, 1'b0, 16'sh0, 1'b0}
   };

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // One sample through the shadow filter: feedback products first, saturate mid,
   // then the feedforward sum at full precision for the clear test.
   // Every product is floored by 14 bits (arithmetic shift).
   function automatic filt_beat_type filter_sample(input logic signed [SampleWidth-1:0] x,
                                                   input logic last);
      longint        mid;
      longint        acc;
      filt_beat_type r;
      mid = longint'(x)
          - ((longint'(gain_a1) * longint'(hist_newer)) >>> FracShift)
          - ((longint'(gain_a2) * longint'(hist_older)) >>> FracShift);
      if (mid > MidMax)
         mid = MidMax;
      else if (mid < -MidMax - 1)
         mid = -MidMax - 1;
      acc = ((longint'(gain_b0) * mid) >>> FracShift)
          + ((longint'(gain_b1) * longint'(hist_newer)) >>> FracShift)
          + ((longint'(gain_b2) * longint'(hist_older)) >>> FracShift);
      r.cleared = acc > longint'(clip_thr);
      // a clear zeroes both entries before mid shifts in, so older ends up zero
      hist_older = r.cleared ? '0 : hist_newer;
      hist_newer = mid[DelayWidth-1:0];
      if (acc > OutMax)
         acc = OutMax;
      else if (acc < -OutMax - 1)
         acc = -OutMax - 1;
      r.smp  = acc[SampleWidth-1:0];
      r.last = last;
      return r;
   endfunction

   // Random register value. Phase 0 puts every register at its minimum, phase 1 at its
   // maximum; later phases mix extremes, reset values, small and full-range values.
   function automatic logic [CsrWidth-1:0] pick_setting(input logic [CsrIdxWidth-1:0] idx,
                                                        input int phase);
      logic [CsrWidth-1:0] v;
      int                  sel;
      sel = (phase < 2) ? phase : int'($urandom_range(0, 9));
      v   = CsrWidth'($urandom);   // bits above a coefficient's width are don't-care
      if (idx == bq_pkg::CSR_THR) begin
         case (sel)
            0:          v = 24'h800000;
            1:          v = 24'h7FFFFF;
            2:          v = bq_pkg::THR_RESET;
            3, 4, 5, 6: v = CsrWidth'($urandom_range(0, 131071) - 65536);
            default:    ;
         endcase
      end else begin
         case (sel)
            0:       v[CoefWidth-1:0] = 16'h8000;
            1:       v[CoefWidth-1:0] = 16'h7FFF;
            2:       v[CoefWidth-1:0] = (idx == bq_pkg::CSR_B0) ? bq_pkg::B0_RESET : '0;
            3, 4, 5: v[CoefWidth-1:0] = CoefWidth'($urandom_range(0, 8191) - 4096);
            default: ;
         endcase
      end
      return v;
   endfunction

   function automatic logic signed [SampleWidth-1:0] pick_sample();
      logic signed [SampleWidth-1:0] s;
      case ($urandom_range(0, 15))
         0:       s = 16'sh8000;
         1:       s = 16'sh7FFF;
         2:       s = '0;
         3, 4:    s = SampleWidth'($urandom_range(0, 2047) - 1024);
         default: s = SampleWidth'($urandom);
      endcase
      return s;
   endfunction

   function automatic void flag_beat(input string what, input filt_beat_type want,
                                     input filt_beat_type got);
      mismatches++;
      if (mismatches <= MaxReports)
         $display("%0t: %s: expected out=%0d clr=%0b last=%0b, got out=%0d clr=%0b last=%0b",
                  $realtime, what, want.smp, want.cleared, want.last,
                  got.smp, got.cleared, got.last);
   endfunction

   // Drop valid, let every outstanding beat come back, then give the sequencer time
   // to park in its wait-for-sample step. Coefficient writes are only legal after this.
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (expected_beats.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // Drives one write for the coming edge; the caller lowers csr_we after the last one.
   task automatic csr_write(input logic [CsrIdxWidth-1:0] idx, input logic [CsrWidth-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         bq_pkg::CSR_B0:  gain_b0  = data[CoefWidth-1:0];
         bq_pkg::CSR_B1:  gain_b1  = data[CoefWidth-1:0];
         bq_pkg::CSR_B2:  gain_b2  = data[CoefWidth-1:0];
         bq_pkg::CSR_A1:  gain_a1  = data[CoefWidth-1:0];
         bq_pkg::CSR_A2:  gain_a2  = data[CoefWidth-1:0];
         bq_pkg::CSR_THR: clip_thr = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // One input beat. Valid stays high on return so back-to-back beats need no dip;
   // settle() and idle gaps lower it. A typed row supplies its own expected beat,
   // the shadow filter still runs to keep the delay line in step.
   task automatic send_beat(input logic signed [SampleWidth-1:0] x, input logic last,
                            input bit typed, input filt_beat_type typed_beat);
      filt_beat_type predicted;
      if (!steady && $urandom_range(0, 99) < 38) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.sample_in     <= x;
      req_ch.last_in_block <= last;
      do @(posedge clock); while (!req_ch.ready);
      predicted = filter_sample(x, last);
      expected_beats = {expected_beats, (typed ? typed_beat : predicted)};
   endtask

   // Stimulus
   initial begin
      int guard;
      reset                <= 1'b1;
      csr_we               <= 1'b0;
      csr_index            <= bq_pkg::CSR_B0;
      csr_wdata            <= '0;
      req_ch.valid         <= 1'b0;
      req_ch.sample_in     <= '0;
      req_ch.last_in_block <= 1'b0;
      gain_b0    = bq_pkg::B0_RESET;
      gain_b1    = '0;
      gain_b2    = '0;
      gain_a1    = '0;
      gain_a2    = '0;
      clip_thr   = bq_pkg::THR_RESET;
      hist_newer = '0;
      hist_older = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      settle();

      // Directed table
      for (int i = 0; i < PlanLen; i++) begin
         if (plan[i].kind == ROW_WRITE) begin
            if (i == 0 || plan[i-1].kind != ROW_WRITE)
               settle();
            csr_write(plan[i].idx, plan[i].wdata);
            if (i == PlanLen - 1 || plan[i+1].kind != ROW_WRITE)
               csr_we <= 1'b0;
         end else begin
            send_beat(plan[i].smp, plan[i].last, plan[i].typed,
                      '{plan[i].y, plan[i].clr, plan[i].last});
         end
      end

      // Random part: a fresh coefficient bank every PhaseLen beats
      for (int n = 0; n < RandomItems; n++) begin
         if (n % PhaseLen == 0) begin
            settle();
            for (logic [CsrIdxWidth-1:0] idx = bq_pkg::CSR_B0; idx <= bq_pkg::CSR_THR; idx++)
               csr_write(idx, pick_setting(idx, n / PhaseLen));
            if ($urandom_range(0, 1) == 1)
               csr_write($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI,
                         CsrWidth'($urandom));
            csr_we <= 1'b0;
         end else if ($urandom_range(0, 199) == 0) begin
            settle();   // sender holds off until the pipe is empty
         end
         steady = (n >= SteadyFirst && n < SteadyLast);
         send_beat(pick_sample(), $urandom_range(0, 7) == 0, 1'b0, '0);
      end
      steady = 1'b0;
      req_ch.valid <= 1'b0;

      guard = 0;
      while (expected_beats.size() != 0 && guard < EndWaitCycles) begin
         @(posedge clock);
         guard++;
      end
      repeat (DrainCycles) @(posedge clock);   // catches stray late beats
      if (mismatches == 0 && expected_beats.size() == 0)
         $display("biquad_df2_with_overload_clear_tb: done, clean");
      else
         $display("biquad_df2_with_overload_clear_tb: done, errors");
      $finish;
   end

   // Result side: check the beat taken at this edge, then pick ready for the next one
   initial begin
      filt_beat_type want;
      filt_beat_type got;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.sample_out, rsp_ch.cleared, rsp_ch.last_out};
            if (expected_beats.size() == 0) begin
               flag_beat("beat with nothing expected", '0, got);
            end else begin
               want = expected_beats.pop_front();
               if (got.smp !== want.smp || got.cleared !== want.cleared
                   || got.last !== want.last)
                  flag_beat("result mismatch", want, got);
            end
         end
         rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 38);
      end
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("biquad_df2_with_overload_clear_tb: done, errors");
      $finish;
   end

endmodule
